FILE: sv/lox_lexical_scanner_unit_macros.svh
// Assertion macros for the lexical scanner checker.
`ifndef LOX_LEXICAL_SCANNER_UNIT_MACROS_SVH
`define LOX_LEXICAL_SCANNER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LLS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but the property must hold in the cycle after the trigger.
`define LLS_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// Types, token kinds and helpers shared by the lexical scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lls_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int LINE_BITS     = 24;
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_BITS       = 8 * KEYWORD_CHARS;
    localparam int OUT_W         = 24;
    localparam int MAX_TOKS      = 4;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    // token kinds
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_BANG_EQ = 6'd12;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_EQ_EQ   = 6'd14;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_GT_EQ   = 6'd16;
    localparam logic [5:0] K_LESS    = 6'd17;
    localparam logic [5:0] K_LT_EQ   = 6'd18;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_EOF     = 6'd38;
    localparam logic [5:0] K_ERR_CHR = 6'd39;
    localparam logic [5:0] K_ERR_STR = 6'd40;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_final;
    } char_req_t;

    typedef struct packed {
        logic [5:0]       token_kind;
        logic [OUT_W-1:0] token_start;
        logic [OUT_W-1:0] token_length;
        logic [OUT_W-1:0] line_number;
        logic             run_end;
    } tok_req_t;

    typedef tok_req_t [MAX_TOKS-1:0] tok_vec_t;

    function automatic logic [OUT_W-1:0] off_to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OUT_W+OFFSET_BITS-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] line_to_out(input logic [LINE_BITS-1:0] v);
        logic [OUT_W+LINE_BITS-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    function automatic tok_req_t mk_tok(input logic [5:0] kind,
                                        input logic [OFFSET_BITS-1:0] s,
                                        input logic [OFFSET_BITS-1:0] e,
                                        input logic [LINE_BITS-1:0] ln);
        tok_req_t t;
        t.token_kind   = kind;
        t.token_start  = off_to_out(s);
        t.token_length = off_to_out(e - s);
        t.line_number  = line_to_out(ln);
        t.run_end      = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lls_kw_match.sv
// ----------------------------------------------------------------------------
// lls_kw_match
// Maps the buffered identifier prefix to a keyword kind or identifier.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_kw_match (
    input  wire logic [lls_pkg::KW_BITS-1:0] kw_buf,
    input  wire logic                        kw_ovf,
    output logic [5:0]                       kind
);
    import lls_pkg::*;

    localparam logic [63:0] KW_TAB [16] = '{
        64'h616E64,       64'h636C617373,   64'h656C7365,   64'h66616C7365,
        64'h66756E,       64'h666F72,       64'h6966,       64'h6E696C,
        64'h6F72,         64'h7072696E74,   64'h72657475726E, 64'h7375706572,
        64'h74686973,     64'h74727565,     64'h766172,     64'h7768696C65
    };

    logic [63:0] buf64;

    assign buf64 = 64'(kw_buf);

    always_comb
    begin
        kind = K_IDENT;
        if (!kw_ovf)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (buf64 == KW_TAB[i])
                begin
                    kind = K_KW0 + 6'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/lls_core.sv
// ----------------------------------------------------------------------------
// lls_core
// Scanner state and per-character token logic; one character per step.
// ----------------------------------------------------------------------------
`default_nettype none

module lls_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire lls_pkg::char_req_t item,
    output lls_pkg::tok_vec_t       toks,
    output logic [2:0]              tok_cnt
);
    import lls_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_BANG, M_EQ, M_GT, M_LT, M_SLASH, M_COMMENT,
        M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
    } mode_t;

    typedef struct packed {
        tok_req_t   t0;
        tok_req_t   t1;
        logic [1:0] cnt;
    } flush_t;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] ls_reg, ls_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [KW_BITS-1:0]     kb_reg, kb_next;
    logic                   ko_reg, ko_next;

    logic [KW_BITS-1:0] kb_step;
    logic               ko_step;
    logic [5:0]         idk_old, idk_new;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic flush_t flush_f(input mode_t m,
                                       input logic [OFFSET_BITS-1:0] ls,
                                       input logic [OFFSET_BITS-1:0] e,
                                       input logic [LINE_BITS-1:0] ln,
                                       input logic [5:0] idk);
        flush_t f;
        logic [OFFSET_BITS-1:0] em1;
        em1   = e - OFFSET_BITS'(1);
        f.t0  = mk_tok(K_NUMBER, ls, e, ln);
        f.t1  = mk_tok(K_DOT, em1, e, ln);
        f.cnt = 2'd1;
        case (m)
            M_BANG:  f.t0 = mk_tok(K_BANG, ls, e, ln);
            M_EQ:    f.t0 = mk_tok(K_EQUAL, ls, e, ln);
            M_GT:    f.t0 = mk_tok(K_GREATER, ls, e, ln);
            M_LT:    f.t0 = mk_tok(K_LESS, ls, e, ln);
            M_SLASH: f.t0 = mk_tok(K_SLASH, ls, e, ln);
            M_INT:   f.t0 = mk_tok(K_NUMBER, ls, e, ln);
            M_FRAC:  f.t0 = mk_tok(K_NUMBER, ls, e, ln);
            M_DOT:
            begin
                f.t0  = mk_tok(K_NUMBER, ls, em1, ln);
                f.cnt = 2'd2;
            end
            M_IDENT: f.t0 = mk_tok(idk, ls, e, ln);
            default: f.cnt = 2'd0;
        endcase
        return f;
    endfunction

    // identifier buffer as it stands after this character
    always_comb
    begin
        kb_step = kb_reg;
        ko_step = ko_reg;
        if (mode_reg == M_IDENT && (is_alpha(item.char_code) || is_digit(item.char_code)))
        begin
            if (!ko_reg)
            begin
                if (kb_reg[KW_BITS-1 -: 8] != 8'd0)
                begin
                    ko_step = 1'b1;
                end
                else
                begin
                    kb_step = {kb_reg[KW_BITS-9:0], item.char_code};
                end
            end
        end
        else if (is_alpha(item.char_code) && mode_reg != M_STRING && mode_reg != M_COMMENT)
        begin
            kb_step = KW_BITS'(item.char_code);
            ko_step = 1'b0;
        end
    end

    lls_kw_match u_kw_old (.kw_buf(kb_reg),  .kw_ovf(ko_reg),  .kind(idk_old));
    lls_kw_match u_kw_new (.kw_buf(kb_step), .kw_ovf(ko_step), .kind(idk_new));

    always_comb
    begin
        logic [7:0]             c;
        logic [OFFSET_BITS-1:0] p, p1;
        logic                   fresh;
        logic [2:0]             n;
        flush_t                 f;
        logic [5:0]             k2;

        c     = item.char_code;
        p     = pos_reg;
        p1    = (pos_reg != OFF_MAX) ? pos_reg + OFFSET_BITS'(1) : pos_reg;
        fresh = 1'b0;
        n     = 3'd0;
        toks  = '0;
        mode_next = mode_reg;
        ls_next   = ls_reg;
        line_next = line_reg;
        kb_next   = kb_step;
        ko_next   = ko_step;
        f         = '0;
        k2        = K_LT_EQ;

        case (mode_reg)
            M_BANG, M_EQ, M_GT, M_LT:
            begin
                if (c == "=")
                begin
                    case (mode_reg)
                        M_BANG:  k2 = K_BANG_EQ;
                        M_EQ:    k2 = K_EQ_EQ;
                        M_GT:    k2 = K_GT_EQ;
                        default: k2 = K_LT_EQ;
                    endcase
                    toks[n[1:0]] = mk_tok(k2, ls_reg, p1, line_next);
                    n = n + 3'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = M_COMMENT;
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c == "\n")
                begin
                    mode_next = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_STRING:
            begin
                if (c == "\"")
                begin
                    toks[n[1:0]] = mk_tok(K_STRING, ls_reg + OFFSET_BITS'(1), p, line_next);
                    n = n + 3'd1;
                    mode_next = M_IDLE;
                end
                else if (c == "\n" && line_reg != LINE_MAX)
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
            M_INT:
            begin
                if (c == ".")
                begin
                    mode_next = M_DOT;
                end
                else if (!is_digit(c))
                begin
                    fresh = 1'b1;
                end
            end
            M_DOT:
            begin
                if (is_digit(c))
                begin
                    mode_next = M_FRAC;
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (!is_digit(c))
                begin
                    fresh = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (!(is_alpha(c) || is_digit(c)))
                begin
                    fresh = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        if (fresh)
        begin
            // close the pending token at this offset
            f = flush_f(mode_reg, ls_reg, p, line_next, idk_old);
            if (f.cnt != 2'd0)
            begin
                toks[n[1:0]] = f.t0;
                n = n + 3'd1;
            end
            if (f.cnt == 2'd2)
            begin
                toks[n[1:0]] = f.t1;
                n = n + 3'd1;
            end
            mode_next = M_IDLE;
            ls_next   = p;
            k2        = K_ERR_CHR;
            case (c)
                "(": k2 = K_LPAREN;
                ")": k2 = K_RPAREN;
                "{": k2 = K_LBRACE;
                "}": k2 = K_RBRACE;
                ",": k2 = K_COMMA;
                ".": k2 = K_DOT;
                "-": k2 = K_MINUS;
                "+": k2 = K_PLUS;
                ";": k2 = K_SEMI;
                "*": k2 = K_STAR;
                "!": mode_next = M_BANG;
                "=": mode_next = M_EQ;
                ">": mode_next = M_GT;
                "<": mode_next = M_LT;
                "/": mode_next = M_SLASH;
                "\"": mode_next = M_STRING;
                " ", "\r", "\t": k2 = K_EOF;
                "\n":
                begin
                    k2 = K_EOF;
                    if (line_reg != LINE_MAX)
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end
                default:
                begin
                    if (is_digit(c))
                    begin
                        mode_next = M_INT;
                    end
                    else if (is_alpha(c))
                    begin
                        mode_next = M_IDENT;
                    end
                end
            endcase
            // single-byte token unless the byte opened a longer lexeme or was blank
            if (mode_next == M_IDLE && k2 != K_EOF)
            begin
                toks[n[1:0]] = mk_tok(k2, p, p1, line_next);
                n = n + 3'd1;
            end
        end

        pos_next = p1;

        if (item.is_final)
        begin
            if (mode_next == M_STRING)
            begin
                toks[n[1:0]] = mk_tok(K_ERR_STR, ls_next + OFFSET_BITS'(1), p1, line_next);
                n = n + 3'd1;
            end
            else
            begin
                f = flush_f(mode_next, ls_next, p1, line_next, idk_new);
                if (f.cnt != 2'd0)
                begin
                    toks[n[1:0]] = f.t0;
                    n = n + 3'd1;
                end
                if (f.cnt == 2'd2)
                begin
                    toks[n[1:0]] = f.t1;
                    n = n + 3'd1;
                end
            end
            toks[n[1:0]] = mk_tok(K_EOF, p1, p1, line_next);
            n = n + 3'd1;
            mode_next = M_IDLE;
            pos_next  = '0;
            ls_next   = '0;
            line_next = LINE_BITS'(1);
            kb_next   = '0;
            ko_next   = 1'b0;
        end

        if (n != 3'd0)
        begin
            toks[n[1:0] - 2'd1].run_end = 1'b1;
        end
        tok_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            ls_reg   <= '0;
            line_reg <= LINE_BITS'(1);
            kb_reg   <= '0;
            ko_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ls_reg   <= ls_next;
            line_reg <= line_next;
            kb_reg   <= kb_next;
            ko_reg   <= ko_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lox_lexical_scanner_unit.sv
// The first token of a character request passes the input register and then the token buffer.
// Throughput: one character per cycle while each character yields at most one token and tok_stall
// stays low; a character that yields more tokens holds the next one until the single output port
// has drained the token buffer, one token a cycle while tok_stall is low.
// Reset (rst_n low, async): scanner at text start, line 1, all buffers empty.
// ----------------------------------------------------------------------------
// lox_lexical_scanner_unit
// Streaming lexical scanner: one source byte in, zero to four tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

module lox_lexical_scanner_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire lls_pkg::char_req_t char_req,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output lls_pkg::tok_req_t       tok_req
);
    import lls_pkg::*;

    // input register
    logic      in_valid_reg, in_valid_next;
    char_req_t in_item_reg;

    // token buffer: filled in one go, drained one token per cycle while tok_stall is low
    tok_vec_t   buf_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] rd_reg, rd_next;

    tok_vec_t   toks;
    logic [2:0] tok_cnt;
    logic       pop, buf_free, step, take;

    lls_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (in_item_reg),
        .toks    (toks),
        .tok_cnt (tok_cnt)
    );

    assign tok_valid = (cnt_reg != 3'd0);
    assign tok_req   = buf_reg[rd_reg];
    assign pop       = tok_valid && !tok_stall;

    // buffer can take a new set once its last token leaves
    assign buf_free   = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && pop);
    assign step       = in_valid_reg && buf_free;
    assign char_stall = in_valid_reg && !buf_free;
    assign take       = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (step)
        begin
            cnt_next = tok_cnt;
            rd_next  = 2'd0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            rd_reg       <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            rd_reg       <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= char_req;
        end
        if (step)
        begin
            buf_reg <= toks;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lls_checker.sv
// ----------------------------------------------------------------------------
// lls_checker
// Port-level checks on the lexical scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lox_lexical_scanner_unit_macros.svh"

module lls_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               char_valid,
    input wire logic               char_stall,
    input wire lls_pkg::char_req_t char_req,
    input wire logic               tok_valid,
    input wire logic               tok_stall,
    input wire lls_pkg::tok_req_t  tok_req
);
    import lls_pkg::*;

    `LLS_ASSERT_NEXT(a_tok_hold, tok_valid && tok_stall, tok_valid, "token dropped while stalled")
    `LLS_ASSERT_NEXT(a_tok_stable, tok_valid && tok_stall, $stable(tok_req), "stalled token changed")
    `LLS_ASSERT_NEXT(a_req_hold, char_valid && char_stall, $stable(char_req), "stalled request changed")
    `LLS_ASSERT(a_stall_cause, char_stall |-> tok_valid, "input stalled with no token pending")
    `LLS_ASSERT(a_eof_last, (tok_valid && tok_req.token_kind == K_EOF) |-> tok_req.run_end, "EOF not last")

endmodule

bind lox_lexical_scanner_unit lls_checker u_lls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (char_req),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_req    (tok_req)
);

`default_nettype wire
